// ----- rtl/core/mhpq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhpq_pkg: shared types and codes of the min-heap priority queue
// Request and result structs, request and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int unsigned IdW    = 16;
  localparam int unsigned CostW  = 24;
  localparam int unsigned CountW = 11;

  typedef enum logic [1:0] {
    REQ_PUSH = 2'd0,
    REQ_POP  = 2'd1,
    REQ_DEC  = 2'd2,
    REQ_NONE = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic [IdW-1:0]   item_id;
    logic [CostW-1:0] item_cost;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IdW-1:0]    popped_id;
    logic [CostW-1:0]  popped_cost;
    logic [CountW-1:0] entry_count;
  } rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/mhpq_ram.sv -----
// ----------------------------------------------------------------------------
// mhpq_ram: generic single-port RAM
// One access per cycle at one address, registered read data; a write also reads the old data.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_ram #(
  parameter int unsigned Width = 40,
  parameter int unsigned Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/core/min_heap_priority_queue.sv -----
// ----------------------------------------------------------------------------
// min_heap_priority_queue: binary min-heap with push, pop and decrease-key
// Sequencer over one single-port heap RAM and one shared key comparator.
// ----------------------------------------------------------------------------
// A push climbs level by level, a pop sinks level by level, and a decrease
// scans the entries one by one and then climbs. Status-only results go
// straight to the response state. One request at a time; busy is high
// meanwhile.
// Throughput is set by the single RAM port: every read and write shares it.
// Reset clears the fill count and the sequencer; heap contents are not cleared.
// The result strobe cannot be stalled by the receiver.
`default_nettype none

module min_heap_priority_queue #(
  parameter int unsigned CAPACITY = 1024
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire mhpq_pkg::req_t req_i,
  output logic               done_o,
  output mhpq_pkg::rsp_t     rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = mhpq_pkg::IdW + mhpq_pkg::CostW;
  localparam logic [CW-1:0] CapC = CW'(CAPACITY);

  typedef struct packed {
    logic [mhpq_pkg::IdW-1:0]   id;
    logic [mhpq_pkg::CostW-1:0] cost;
  } ent_t;

  typedef enum logic [4:0] {
    S_IDLE, S_RESP,
    S_UP_RD, S_UP_WT, S_UP_CMP, S_UP_WP,
    S_PO_RD0, S_PO_WT0, S_PO_RDL, S_PO_WTL, S_PO_WR0,
    S_DN_RDL, S_DN_WTL, S_DN_RDR, S_DN_WTR, S_DN_DEC, S_DN_DR, S_DN_WC, S_DN_CUR,
    S_SC_RD, S_SC_WT, S_SC_CMP
  } state_e;

  state_e            state_q;
  logic [CW-1:0]     cnt_q;
  logic [CW:0]       pos_q;     // wide enough for 2*pos+2
  logic [CW:0]       aux_q;     // child index / scan index
  ent_t              cur_q;     // moving entry
  ent_t              oth_q;     // entry read from RAM
  ent_t              lft_q;
  logic              lft_best_q; // left child does not exceed the moving entry
  logic [1:0]        st_q;
  ent_t              pop_q;
  logic              tie_q;     // swap on equal keys while climbing
  logic [mhpq_pkg::IdW-1:0]   key_id_q;
  logic [mhpq_pkg::CostW-1:0] key_cost_q;
  mhpq_pkg::rsp_t    rsp_q;
  logic              done_q;

  logic          we;
  logic [AW-1:0] addr;
  ent_t          wdata, rdata;

  mhpq_ram #(.Width(EW), .Depth(CAPACITY)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // Shared key comparator: a >= b (or a > b for strict climbs).
  logic [mhpq_pkg::CostW-1:0] cmp_a, cmp_b;
  logic cmp_ge, cmp_gt;
  assign cmp_ge = cmp_a >= cmp_b;
  assign cmp_gt = cmp_a > cmp_b;

  logic [CW:0] par_idx;
  assign par_idx = (pos_q - 1'b1) >> 1;

  always_comb begin
    we    = 1'b0;
    addr  = AW'(pos_q);
    wdata = cur_q;
    cmp_a = oth_q.cost;
    cmp_b = cur_q.cost;
    unique case (state_q)
      S_UP_RD:  addr = AW'(par_idx);
      S_UP_WP:  begin we = 1'b1; addr = AW'(pos_q); wdata = oth_q; end
      S_PO_RD0: addr = '0;
      S_PO_RDL: addr = AW'(cnt_q);
      // Keep the last slot addressed so its data is still there next cycle.
      S_PO_WTL: addr = AW'(cnt_q);
      S_PO_WR0: begin we = 1'b1; addr = '0; wdata = rdata; end
      S_DN_RDL: addr = AW'(aux_q);
      S_DN_RDR: addr = AW'(aux_q + 1'b1);
      S_DN_DEC: begin cmp_a = cur_q.cost; cmp_b = lft_q.cost; end
      S_DN_DR:  begin cmp_a = lft_q.cost; cmp_b = oth_q.cost; end
      S_DN_WC:  begin we = 1'b1; addr = AW'(pos_q); wdata = oth_q; end
      S_DN_CUR: begin we = 1'b1; addr = AW'(pos_q); wdata = cur_q; end
      S_SC_RD:  addr = AW'(aux_q);
      S_SC_CMP: cmp_b = key_cost_q;
      S_IDLE, S_RESP:    we = 1'b0;
      S_UP_CMP, S_UP_WT: begin
        // Finishing a climb writes the moving entry at its final slot.
        if (state_q == S_UP_CMP) begin
          we = 1'b1; addr = AW'(pos_q); wdata = cur_q;
        end
      end
      default: we = 1'b0;
    endcase
  end

  // Final write of a climb is redone harmlessly at each compare: the slot
  // pos_q always ends up holding cur_q once the climb stops.

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            st_q       <= mhpq_pkg::ST_OK;
            pop_q      <= '0;
            cur_q      <= '{id: req_i.item_id, cost: req_i.item_cost};
            key_id_q   <= req_i.item_id;
            key_cost_q <= req_i.item_cost;
            unique case (req_i.req_type)
              mhpq_pkg::REQ_PUSH: begin
                if (cnt_q == CapC) begin
                  st_q <= mhpq_pkg::ST_FULL; state_q <= S_RESP;
                end else begin
                  pos_q   <= (CW+1)'(cnt_q);
                  cnt_q   <= cnt_q + 1'b1;
                  tie_q   <= 1'b1;
                  state_q <= (cnt_q == '0) ? S_UP_CMP : S_UP_RD;
                end
              end
              mhpq_pkg::REQ_POP: begin
                if (cnt_q == '0) begin
                  st_q <= mhpq_pkg::ST_EMPTY; state_q <= S_RESP;
                end else begin
                  cnt_q   <= cnt_q - 1'b1;
                  state_q <= S_PO_RD0;
                end
              end
              mhpq_pkg::REQ_DEC: begin
                aux_q   <= '0;
                tie_q   <= 1'b0;
                if (cnt_q == '0) begin
                  st_q <= mhpq_pkg::ST_NOTFOUND; state_q <= S_RESP;
                end else begin
                  state_q <= S_SC_RD;
                end
              end
              default: state_q <= S_RESP;
            endcase
          end
        end
        // ---- climb: pos_q holds the slot of cur_q (not yet written)
        S_UP_RD: state_q <= S_UP_WT;
        S_UP_WT: begin oth_q <= rdata; state_q <= S_UP_CMP; end
        S_UP_CMP: begin
          // The write of cur_q at pos_q happens here; continue if parent moves.
          if (pos_q != '0 && (tie_q ? cmp_ge : cmp_gt)) begin
            state_q <= S_UP_WP;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_UP_WP: begin
          // Parent drops into pos_q; cur_q climbs to the parent slot.
          pos_q   <= par_idx;
          state_q <= (par_idx == '0) ? S_UP_CMP : S_UP_RD;
        end
        // ---- pop
        S_PO_RD0: state_q <= S_PO_WT0;
        S_PO_WT0: begin pop_q <= rdata; state_q <= S_PO_RDL; end
        S_PO_RDL: state_q <= S_PO_WTL;
        S_PO_WTL: state_q <= (cnt_q == '0) ? S_RESP : S_PO_WR0;
        S_PO_WR0: begin
          cur_q   <= rdata;
          pos_q   <= '0;
          aux_q   <= (CW+1)'(1);
          state_q <= S_DN_RDL;
        end
        // ---- sink: pos_q slot holds cur_q, aux_q is left child
        S_DN_RDL: state_q <= (aux_q < (CW+1)'(cnt_q)) ? S_DN_WTL : S_RESP;
        S_DN_WTL: begin lft_q <= rdata; state_q <= S_DN_RDR; end
        S_DN_RDR: state_q <= S_DN_WTR;
        S_DN_WTR: begin
          oth_q   <= rdata;
          state_q <= S_DN_DEC;
        end
        S_DN_DEC: begin
          // cmp_ge: cur >= left. With a right child, hold the better of the
          // two in lft_q and weigh it against the right child next cycle.
          if (aux_q + 1'b1 < (CW+1)'(cnt_q)) begin
            if (!cmp_ge) begin
              lft_q <= cur_q;
            end
            lft_best_q <= cmp_ge;
            state_q    <= S_DN_DR;
          end else if (cmp_ge) begin
            oth_q <= lft_q; state_q <= S_DN_WC;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_DN_DR: begin
          // cmp_ge: best so far >= right, so the right child moves up.
          if (cmp_ge) begin
            aux_q <= aux_q + 1'b1; state_q <= S_DN_WC;
          end else if (lft_best_q) begin
            oth_q <= lft_q; state_q <= S_DN_WC;
          end else begin
            state_q <= S_RESP;
          end
        end
        S_DN_WC: begin
          // Child moves up into pos_q; cur_q now sits at aux_q.
          pos_q   <= aux_q;
          aux_q   <= (aux_q << 1) + 1'b1;
          state_q <= S_DN_CUR;
        end
        // ---- decrease scan
        S_SC_RD: state_q <= S_SC_WT;
        S_SC_WT: begin oth_q <= rdata; state_q <= S_SC_CMP; end
        S_SC_CMP: begin
          if (oth_q.id == key_id_q) begin
            pos_q <= aux_q;
            if (cmp_gt) begin
              cur_q   <= '{id: oth_q.id, cost: key_cost_q};
              state_q <= (aux_q == '0) ? S_UP_CMP : S_UP_RD;
            end else begin
              state_q <= S_RESP;
            end
          end else if (aux_q + 1'b1 == (CW+1)'(cnt_q)) begin
            st_q    <= mhpq_pkg::ST_NOTFOUND;
            state_q <= S_RESP;
          end else begin
            aux_q   <= aux_q + 1'b1;
            state_q <= S_SC_RD;
          end
        end
        S_DN_CUR: begin
          // Drop the moving entry into the child slot it just took over.
          state_q <= S_DN_RDL;
        end
        S_RESP: begin
          done_q  <= 1'b1;
          rsp_q   <= '{status: st_q, popped_id: pop_q.id, popped_cost: pop_q.cost,
                       entry_count: mhpq_pkg::CountW'(cnt_q)};
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire
